FILE: rtl/core/vsdt_pkg.sv
package vsdt_pkg;

    // item kinds
    localparam logic [1:0] KIND_TICK  = 2'd0;
    localparam logic [1:0] KIND_WRITE = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;

    // register window indexes
    localparam logic [2:0] REG_CTRL   = 3'd0;
    localparam logic [2:0] REG_MASK   = 3'd1;
    localparam logic [2:0] REG_STATUS = 3'd2;
    localparam logic [2:0] REG_SCROLL = 3'd5;
    localparam logic [2:0] REG_ADDR   = 3'd6;
    localparam logic [2:0] REG_DATA   = 3'd7;

    // address field masks
    localparam logic [15:0] NT_SELECT_MASK  = 16'h0c00;
    localparam logic [15:0] SCROLL_Y_KEEP   = 16'h8c1f;
    localparam logic [15:0] HORZ_COPY_MASK  = 16'h041f;
    localparam logic [15:0] VERT_COPY_MASK  = 16'h7be0;
    localparam logic [15:0] FINE_Y_MASK     = 16'h7000;
    localparam logic [15:0] ACCESS_ADDR_MSK = 16'h3fff;
    localparam logic [7:0]  COARSE_DATA_MSK = 8'hf8;

    // dot and line timing
    localparam logic [8:0] SKIP_DOT        = 9'd339;
    localparam logic [9:0] DOTS_PER_LINE   = 10'd341;
    localparam logic [9:0] LINES_PER_FRAME = 10'd262;
    localparam logic [8:0] VBLANK_LINE     = 9'd241;
    localparam logic [8:0] PRERENDER_LINE  = 9'd261;
    localparam logic [8:0] VISIBLE_LINES   = 9'd240;

    // reset values
    localparam logic [7:0] CTRL_RESET = 8'h80;
    localparam logic [8:0] DOT_RESET  = 9'd340;
    localparam logic [8:0] LINE_RESET = 9'd240;

    typedef struct packed {
        logic [1:0] kind;
        logic [2:0] reg_req;
        logic [7:0] data;
    } t_vsdt_in;

    typedef struct packed {
        logic [7:0]  read_data;
        logic        access_valid;
        logic [13:0] access_addr;
        logic [15:0] vram_addr;
        logic [2:0]  fine_scroll_x;
        logic        nmi_pulse;
        logic [8:0]  dot_index;
        logic [8:0]  line_index;
    } t_vsdt_out;

    // coarse x step with horizontal nametable switch
    function automatic logic [15:0] coarse_x_step(input logic [15:0] a);
        logic [15:0] r;
        if (a[4:0] == 5'd31) begin
            r = (a & 16'hffe0) ^ 16'h0400;
        end else begin
            r = a + 16'd1;
        end
        return r;
    endfunction

    // fine y step, carrying into coarse y and the vertical nametable
    function automatic logic [15:0] y_step(input logic [15:0] a);
        logic [15:0] r;
        logic [4:0]  cy;
        if ((a & FINE_Y_MASK) != FINE_Y_MASK) begin
            r = a + 16'h1000;
        end else begin
            r  = a & 16'h8fff;
            cy = r[9:5];
            if (cy == 5'd29) begin
                cy = 5'd0;
                r  = r ^ 16'h0800;
            end else if (cy == 5'd31) begin
                cy = 5'd0;
            end else begin
                cy = cy + 5'd1;
            end
            r[9:5] = cy;
        end
        return r;
    endfunction

endpackage

FILE: rtl/core/video_scroll_address_and_dot_timing_unit.sv
// Scroll address and dot timing unit.
// Input channel: i_valid / o_stall with i_item, one item per accepted edge:
// a dot tick, a register write or a register read in the eight-register
// window. Output channel: o_valid / i_stall with o_item, exactly one result
// per input item, in order.
// An accepted item waits in the input register, then passes the state update
// into the result register, from which it is offered on o_item.
// Throughput: one item per cycle while i_stall is low, set by the single input
// register and the single result register with the state update in between.
// When the receiver stalls, the result register holds its item; one more
// item may sit in the input register, after which o_stall is raised in the
// same cycle as i_stall so nothing is lost.
// Reset (i_rst_n low, synchronous): both stages empty, control 0x80, vblank
// set, dot 340, line 240, all addresses, mask, fine x, the write toggle and
// the odd-frame flag cleared.
module video_scroll_address_and_dot_timing_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  vsdt_pkg::t_vsdt_in  i_item,
    output logic               o_valid,
    input  logic               i_stall,
    output vsdt_pkg::t_vsdt_out o_item
);
    import vsdt_pkg::*;

    // pipeline registers
    logic      r_in_valid;
    t_vsdt_in  r_in_item;
    logic      r_out_valid;
    t_vsdt_out r_out_item;
    t_vsdt_out n_out_item;

    // chip state
    logic [7:0]  r_ctrl, n_ctrl;
    logic [7:0]  r_mask, n_mask;
    logic [15:0] r_temp, n_temp;
    logic [15:0] r_cur, n_cur;
    logic [2:0]  r_fine_x, n_fine_x;
    logic        r_toggle, n_toggle;
    logic        r_vblank, n_vblank;
    logic [8:0]  r_dot, n_dot;
    logic [8:0]  r_line, n_line;
    logic        r_odd, n_odd;

    // handshake
    logic out_adv;
    logic move;
    logic accept;

    // working values
    logic        render;
    logic        rline;
    logic        fetch;
    logic [9:0]  dot_inc;
    logic [9:0]  line_inc;
    logic [15:0] cur_work;
    logic [15:0] temp_work;
    logic [7:0]  rd;
    logic        acc;
    logic [13:0] acc_addr;
    logic        nmi;

    assign out_adv = !r_out_valid || !i_stall;
    assign move    = r_in_valid && out_adv;
    assign o_stall = r_in_valid && !out_adv;
    assign accept  = i_valid && !o_stall;
    assign o_valid = r_out_valid;
    assign o_item  = r_out_item;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (move) begin
            r_in_valid <= 1'b0;
        end
        if (accept) begin
            r_in_item <= i_item;
        end
    end

    // item processing
    always_comb begin
        n_ctrl    = r_ctrl;
        n_mask    = r_mask;
        n_temp    = r_temp;
        n_cur     = r_cur;
        n_fine_x  = r_fine_x;
        n_toggle  = r_toggle;
        n_vblank  = r_vblank;
        n_dot     = r_dot;
        n_line    = r_line;
        n_odd     = r_odd;
        rd        = 8'd0;
        acc       = 1'b0;
        acc_addr  = 14'd0;
        nmi       = 1'b0;
        render    = (r_mask[4] | r_mask[3]);
        rline     = (r_line == PRERENDER_LINE) || (r_line < VISIBLE_LINES);
        fetch     = ((r_dot >= 9'd1) && (r_dot <= 9'd256))
                  || ((r_dot >= 9'd321) && (r_dot <= 9'd336));
        dot_inc   = {1'b0, r_dot} + 10'd1;
        line_inc  = {1'b0, r_line} + 10'd1;
        cur_work  = r_cur;
        temp_work = r_temp;

        case (r_in_item.kind)
            KIND_TICK: begin
                if (render && r_odd && (r_line == PRERENDER_LINE) && (r_dot == SKIP_DOT)) begin
                    // odd frame: jump straight to the start of the frame
                    n_dot  = 9'd0;
                    n_line = 9'd0;
                    n_odd  = ~r_odd;
                end else begin
                    // rendering address updates
                    if (render) begin
                        if ((r_line == PRERENDER_LINE)
                                && (r_dot >= 9'd280) && (r_dot <= 9'd304)) begin
                            cur_work = (cur_work & ~VERT_COPY_MASK) | (r_temp & VERT_COPY_MASK);
                        end
                        if (rline) begin
                            if (fetch && (r_dot[2:0] == 3'd0)) begin
                                cur_work = coarse_x_step(cur_work);
                            end
                            if (r_dot == 9'd256) begin
                                cur_work = y_step(cur_work);
                            end
                            if (r_dot == 9'd257) begin
                                cur_work = (cur_work & ~HORZ_COPY_MASK)
                                         | (r_temp & HORZ_COPY_MASK);
                            end
                        end
                    end
                    n_cur = cur_work;
                    // vblank and nmi
                    if ((r_line == VBLANK_LINE) && (r_dot == 9'd1)) begin
                        n_vblank = 1'b1;
                        nmi      = r_ctrl[7];
                    end
                    if ((r_line == PRERENDER_LINE) && (r_dot == 9'd1)) begin
                        n_vblank = 1'b0;
                    end
                    // dot and line counters
                    if (dot_inc >= DOTS_PER_LINE) begin
                        n_dot = 9'd0;
                        if (line_inc >= LINES_PER_FRAME) begin
                            n_line = 9'd0;
                            n_odd  = ~r_odd;
                        end else begin
                            n_line = line_inc[8:0];
                        end
                    end else begin
                        n_dot = dot_inc[8:0];
                    end
                end
            end
            KIND_WRITE: begin
                unique case (r_in_item.reg_req)
                    REG_CTRL: begin
                        n_ctrl = r_in_item.data;
                        n_temp = (r_temp & ~NT_SELECT_MASK)
                               | {4'd0, r_in_item.data[1:0], 10'd0};
                    end
                    REG_MASK: begin
                        n_mask = r_in_item.data;
                    end
                    REG_SCROLL: begin
                        if (!r_toggle) begin
                            n_temp   = {r_temp[15:5], r_in_item.data[7:3]};
                            n_fine_x = r_in_item.data[2:0];
                        end else begin
                            n_temp = (r_temp & SCROLL_Y_KEEP)
                                   | {1'b0, r_in_item.data[2:0], 2'd0,
                                      r_in_item.data[7:3], 5'd0};
                        end
                        n_toggle = ~r_toggle;
                    end
                    REG_ADDR: begin
                        if (!r_toggle) begin
                            n_temp = {2'd0, r_in_item.data[5:0], r_temp[7:0]};
                        end else begin
                            temp_work = {r_temp[15:8], r_in_item.data};
                            n_temp    = temp_work;
                            n_cur     = temp_work;
                        end
                        n_toggle = ~r_toggle;
                    end
                    REG_DATA: begin
                        acc      = 1'b1;
                        acc_addr = r_cur[13:0];
                        n_cur    = r_cur + (r_ctrl[2] ? 16'd32 : 16'd1);
                    end
                    default: begin
                    end
                endcase
            end
            KIND_READ: begin
                rd = 8'hff;
                if (r_in_item.reg_req == REG_STATUS) begin
                    rd       = {r_vblank, 7'd0};
                    n_vblank = 1'b0;
                    n_temp   = 16'd0;
                    n_toggle = 1'b0;
                end else if (r_in_item.reg_req == REG_DATA) begin
                    acc      = 1'b1;
                    acc_addr = r_cur[13:0];
                    n_cur    = r_cur + (r_ctrl[2] ? 16'd32 : 16'd1);
                end
            end
            default: begin
            end
        endcase

        n_out_item.read_data     = rd;
        n_out_item.access_valid  = acc;
        n_out_item.access_addr   = acc_addr;
        n_out_item.vram_addr     = n_cur;
        n_out_item.fine_scroll_x = n_fine_x;
        n_out_item.nmi_pulse     = nmi;
        n_out_item.dot_index     = n_dot;
        n_out_item.line_index    = n_line;
    end

    // state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_ctrl      <= CTRL_RESET;
            r_mask      <= 8'd0;
            r_temp      <= 16'd0;
            r_cur       <= 16'd0;
            r_fine_x    <= 3'd0;
            r_toggle    <= 1'b0;
            r_vblank    <= 1'b1;
            r_dot       <= DOT_RESET;
            r_line      <= LINE_RESET;
            r_odd       <= 1'b0;
        end else begin
            if (out_adv) begin
                r_out_valid <= move;
            end
            if (move) begin
                r_ctrl   <= n_ctrl;
                r_mask   <= n_mask;
                r_temp   <= n_temp;
                r_cur    <= n_cur;
                r_fine_x <= n_fine_x;
                r_toggle <= n_toggle;
                r_vblank <= n_vblank;
                r_dot    <= n_dot;
                r_line   <= n_line;
                r_odd    <= n_odd;
            end
        end
        if (move) begin
            r_out_item <= n_out_item;
        end
    end

endmodule

FILE: rtl/core/vsdt_checker.sv
module vsdt_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_valid,
    input logic                o_stall,
    input vsdt_pkg::t_vsdt_in  i_item,
    input logic                o_valid,
    input logic                i_stall,
    input vsdt_pkg::t_vsdt_out o_item
);
    import vsdt_pkg::*;

    // a held result keeps its item
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_item)))
        else $error("result item changed while stalled");

    // back-pressure only passes through when the result side is blocked
    a_stall_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled without a blocked result");

    // nmi only on the dot after line 241 dot 1
    a_nmi_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_item.nmi_pulse) |->
            (o_item.line_index == VBLANK_LINE && o_item.dot_index == 9'd2))
        else $error("nmi pulse at the wrong dot");

    // a data-port write taken with the receiver ready comes out as an access
    a_data_wr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && i_item.kind == KIND_WRITE && i_item.reg_req == REG_DATA)
            ##1 !i_stall |=>
            (o_valid && o_item.access_valid && o_item.read_data == 8'h00))
        else $error("data-port write without its access");

    // nothing offered right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

endmodule

bind video_scroll_address_and_dot_timing_unit vsdt_checker u_vsdt_checker (.*);

FILE: tb/scroll_timing_checker.sv
`timescale 1ns / 100ps

module scroll_timing_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_stall,
    input  vsdt_pkg::t_vsdt_in  i_in_item,
    input  logic                i_out_valid,
    input  logic                i_out_stall,
    input  vsdt_pkg::t_vsdt_out i_out_item,
    output int                  o_fail_count,
    output int                  o_pending,
    output int                  o_item_count,
    output int                  o_nmi_count,
    output int                  o_skip_count,
    output int                  o_wrap_count
);
    import vsdt_pkg::*;

    // own copy of the unit's registers and counters
    logic [7:0]  ctrl_r;
    logic [7:0]  mask_r;
    logic [15:0] tmp_addr;
    logic [15:0] cur_addr;
    logic [2:0]  fine_x_r;
    logic        toggle_r;
    logic        vblank_r;
    logic        odd_r;
    int          dot_r;
    int          line_r;

    t_vsdt_out   due_results[$];
    t_vsdt_out   want;
    int          fail_cnt = 0;
    int          item_cnt = 0;
    int          nmi_cnt  = 0;
    int          skip_cnt = 0;
    int          wrap_cnt = 0;

    assign o_fail_count = fail_cnt;
    assign o_item_count = item_cnt;
    assign o_nmi_count  = nmi_cnt;
    assign o_skip_count = skip_cnt;
    assign o_wrap_count = wrap_cnt;

    // coarse x, wrapping into the neighbouring horizontal nametable
    function automatic logic [15:0] next_coarse_x(input logic [15:0] a);
        if (&a[4:0]) begin
            return {a[15:11], ~a[10], a[9:5], 5'd0};
        end
        return a + 16'd1;
    endfunction

    // fine y, carrying into coarse y; row 29 flips the vertical nametable
    function automatic logic [15:0] next_fine_y(input logic [15:0] a);
        logic [15:0] r;
        logic [4:0]  row;
        if (a[14:12] != 3'd7) begin
            return a + 16'h1000;
        end
        r        = a;
        r[14:12] = 3'd0;
        row      = a[9:5];
        if (row == 5'd29) begin
            row   = 5'd0;
            r[11] = ~r[11];
        end else if (row == 5'd31) begin
            row = 5'd0;
        end else begin
            row = row + 5'd1;
        end
        r[9:5] = row;
        return r;
    endfunction

    // data-port access: report the address, then step by 1 or 32
    task automatic data_access(inout t_vsdt_out res);
        logic [15:0] prev;
        prev             = cur_addr;
        res.access_valid = 1'b1;
        res.access_addr  = cur_addr[13:0];
        cur_addr         = cur_addr + (ctrl_r[2] ? 16'd32 : 16'd1);
        if (cur_addr < prev) begin
            wrap_cnt++;
        end
    endtask

    // one dot of timing, with the rendering address updates
    task automatic advance_dot(output logic nmi);
        logic render;
        nmi    = 1'b0;
        render = mask_r[3] | mask_r[4];
        if (render && odd_r && line_r == PRERENDER_LINE && dot_r == SKIP_DOT) begin
            dot_r  = 0;
            line_r = 0;
            odd_r  = ~odd_r;
            skip_cnt++;
            return;
        end
        if (render) begin
            if (line_r == PRERENDER_LINE && dot_r >= 280 && dot_r <= 304) begin
                cur_addr = (cur_addr & ~VERT_COPY_MASK) | (tmp_addr & VERT_COPY_MASK);
            end
            if (line_r == PRERENDER_LINE || line_r < VISIBLE_LINES) begin
                if (((dot_r >= 1 && dot_r <= 256) || (dot_r >= 321 && dot_r <= 336))
                        && dot_r % 8 == 0) begin
                    cur_addr = next_coarse_x(cur_addr);
                end
                if (dot_r == 256) begin
                    cur_addr = next_fine_y(cur_addr);
                end
                if (dot_r == 257) begin
                    cur_addr = (cur_addr & ~HORZ_COPY_MASK) | (tmp_addr & HORZ_COPY_MASK);
                end
            end
        end
        if (line_r == VBLANK_LINE && dot_r == 1) begin
            vblank_r = 1'b1;
            nmi      = ctrl_r[7];
        end
        if (line_r == PRERENDER_LINE && dot_r == 1) begin
            vblank_r = 1'b0;
        end
        dot_r++;
        if (dot_r >= DOTS_PER_LINE) begin
            dot_r = 0;
            line_r++;
            if (line_r >= LINES_PER_FRAME) begin
                line_r = 0;
                odd_r  = ~odd_r;
            end
        end
    endtask

    // work out the result of one accepted item and update the state
    task automatic step_scroll_timing(input t_vsdt_in it, output t_vsdt_out res);
        logic nmi;
        res = '0;
        nmi = 1'b0;
        case (it.kind)
            KIND_TICK: begin
                advance_dot(nmi);
            end
            KIND_WRITE: begin
                case (it.reg_req)
                    REG_CTRL: begin
                        ctrl_r          = it.data;
                        tmp_addr[11:10] = it.data[1:0];
                    end
                    REG_MASK: begin
                        mask_r = it.data;
                    end
                    REG_SCROLL: begin
                        if (!toggle_r) begin
                            tmp_addr[4:0] = it.data[7:3];
                            fine_x_r      = it.data[2:0];
                        end else begin
                            tmp_addr[9:5]   = it.data[7:3];
                            tmp_addr[14:12] = it.data[2:0];
                        end
                        toggle_r = ~toggle_r;
                    end
                    REG_ADDR: begin
                        if (!toggle_r) begin
                            tmp_addr[15:8] = {2'b00, it.data[5:0]};
                        end else begin
                            tmp_addr[7:0] = it.data;
                            cur_addr      = tmp_addr;
                        end
                        toggle_r = ~toggle_r;
                    end
                    REG_DATA: begin
                        data_access(res);
                    end
                    default: begin
                    end
                endcase
            end
            KIND_READ: begin
                res.read_data = 8'hff;
                if (it.reg_req == REG_STATUS) begin
                    res.read_data = {vblank_r, 7'd0};
                    vblank_r      = 1'b0;
                    tmp_addr      = 16'd0;
                    toggle_r      = 1'b0;
                end else if (it.reg_req == REG_DATA) begin
                    data_access(res);
                end
            end
            default: begin
            end
        endcase
        if (nmi) begin
            nmi_cnt++;
        end
        res.vram_addr     = cur_addr;
        res.fine_scroll_x = fine_x_r;
        res.nmi_pulse     = nmi;
        res.dot_index     = dot_r[8:0];
        res.line_index    = line_r[8:0];
    endtask

    task automatic check_field(input string name, input int unsigned exp_v,
                               input int unsigned got_v);
        if (exp_v != got_v) begin
            if (fail_cnt < 64) begin
                $error("%s: expected %0h, got %0h", name, exp_v, got_v);
            end
            fail_cnt++;
        end
    endtask

    // compare outgoing items, then predict the incoming one
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            ctrl_r   = CTRL_RESET;
            mask_r   = 8'd0;
            tmp_addr = 16'd0;
            cur_addr = 16'd0;
            fine_x_r = 3'd0;
            toggle_r = 1'b0;
            vblank_r = 1'b1;
            odd_r    = 1'b0;
            dot_r    = int'(DOT_RESET);
            line_r   = int'(LINE_RESET);
            due_results.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (due_results.size() == 0) begin
                    if (fail_cnt < 64) begin
                        $error("result item with nothing expected");
                    end
                    fail_cnt++;
                end else begin
                    want = due_results.pop_front();
                    check_field("read_data", 32'(want.read_data),
                                32'(i_out_item.read_data));
                    check_field("access_valid", 32'(want.access_valid),
                                32'(i_out_item.access_valid));
                    check_field("access_addr", 32'(want.access_addr),
                                32'(i_out_item.access_addr));
                    check_field("vram_addr", 32'(want.vram_addr),
                                32'(i_out_item.vram_addr));
                    check_field("fine_scroll_x", 32'(want.fine_scroll_x),
                                32'(i_out_item.fine_scroll_x));
                    check_field("nmi_pulse", 32'(want.nmi_pulse),
                                32'(i_out_item.nmi_pulse));
                    check_field("dot_index", 32'(want.dot_index),
                                32'(i_out_item.dot_index));
                    check_field("line_index", 32'(want.line_index),
                                32'(i_out_item.line_index));
                end
            end
            if (i_in_valid && !i_in_stall) begin
                step_scroll_timing(i_in_item, want);
                due_results.push_back(want);
                item_cnt++;
            end
        end
        o_pending <= due_results.size();
    end

endmodule

FILE: tb/video_scroll_address_and_dot_timing_unit_tb.sv
`timescale 1ns / 100ps

module video_scroll_address_and_dot_timing_unit_tb;
    import vsdt_pkg::*;

    // indexes and kinds the unit accepts but does nothing with
    localparam logic [1:0] KIND_SPARE   = 2'd3;
    localparam logic [2:0] REG_OAM_ADDR = 3'd3;
    localparam logic [2:0] REG_OAM_DATA = 3'd4;

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_valid = 1'b0;
    t_vsdt_in  i_item  = '0;
    logic      i_stall = 1'b0;
    logic      o_stall;
    logic      o_valid;
    t_vsdt_out o_item;

    int fail_count;
    int pending;
    int item_count;
    int nmi_count;
    int skip_count;
    int wrap_count;

    int send_idle_pct = 9;
    int recv_idle_pct = 83;
    int items_sent    = 0;
    int random_total  = 0;
    bit long_hold_rq  = 1'b0;

    video_scroll_address_and_dot_timing_unit uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_item  (i_item),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_item  (o_item)
    );

    scroll_timing_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_valid),
        .i_in_stall   (o_stall),
        .i_in_item    (i_item),
        .i_out_valid  (o_valid),
        .i_out_stall  (i_stall),
        .i_out_item   (o_item),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_item_count (item_count),
        .o_nmi_count  (nmi_count),
        .o_skip_count (skip_count),
        .o_wrap_count (wrap_count)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // receiver: random stalls, plus one long hold-off on request
    initial begin : receiver
        int k;
        forever begin
            @(posedge i_clk);
            if (long_hold_rq) begin
                long_hold_rq = 1'b0;
                for (k = 0; k < 48; k++) begin
                    i_stall <= 1'b1;
                    @(posedge i_clk);
                end
            end
            i_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    initial begin
        #20000000;
        $display("video_scroll_address_and_dot_timing_unit_tb failed");
        $finish;
    end

    function automatic t_vsdt_in make_item(input logic [1:0] k, input logic [2:0] r,
                                           input logic [7:0] d);
        t_vsdt_in it;
        it.kind    = k;
        it.reg_req = r;
        it.data    = d;
        return it;
    endfunction

    // offer one item after a random gap and hold it until taken
    task automatic put_item(input t_vsdt_in it);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_item  <= it;
        do @(posedge i_clk); while (o_stall);
        items_sent++;
    endtask

    task automatic write_reg(input logic [2:0] r, input logic [7:0] d);
        put_item(make_item(KIND_WRITE, r, d));
    endtask

    task automatic read_reg(input logic [2:0] r);
        put_item(make_item(KIND_READ, r, 8'($urandom_range(255))));
    endtask

    task automatic run_ticks(input int n);
        int k;
        for (k = 0; k < n; k++) begin
            put_item(make_item(KIND_TICK, 3'($urandom_range(7)), 8'($urandom_range(255))));
        end
    endtask

    task automatic data_port_access();
        if ($urandom_range(1)) begin
            read_reg(REG_DATA);
        end else begin
            write_reg(REG_DATA, 8'($urandom_range(255)));
        end
    endtask

    // one short, mostly well-formed register sequence or a run of dots
    task automatic random_sequence();
        int pick;
        int n;
        int k;
        pick = $urandom_range(99);
        if (pick < 25) begin
            run_ticks($urandom_range(24, 1));
        end else if (pick < 40) begin
            if ($urandom_range(1)) begin
                read_reg(REG_STATUS);
            end
            write_reg(REG_SCROLL, 8'($urandom_range(255)));
            write_reg(REG_SCROLL, 8'($urandom_range(255)));
        end else if (pick < 55) begin
            read_reg(REG_STATUS);
            write_reg(REG_ADDR, 8'($urandom_range(255)));
            write_reg(REG_ADDR, 8'($urandom_range(255)));
            n = $urandom_range(6, 1);
            for (k = 0; k < n; k++) begin
                data_port_access();
            end
        end else if (pick < 65) begin
            write_reg(REG_CTRL, 8'($urandom_range(255)));
        end else if (pick < 73) begin
            write_reg(REG_MASK, 8'($urandom_range(255)));
        end else if (pick < 83) begin
            read_reg(REG_STATUS);
        end else begin
            put_item(make_item(2'($urandom_range(3)), 3'($urandom_range(7)),
                               8'($urandom_range(255))));
        end
    endtask

    task automatic random_mix(input int n);
        int first;
        first = items_sent;
        while (items_sent - first < n) begin
            random_sequence();
        end
        random_total += items_sent - first;
    endtask

    // stimulus
    initial begin
        int k;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // three dots from reset pass the vblank dot, with nmi enabled
        run_ticks(3);
        read_reg(REG_STATUS);
        read_reg(REG_STATUS);
        read_reg(REG_CTRL);
        read_reg(REG_SCROLL);
        write_reg(REG_CTRL, 8'hff);
        write_reg(REG_CTRL, 8'h00);
        write_reg(REG_MASK, 8'h18);
        write_reg(REG_MASK, 8'h00);
        write_reg(REG_SCROLL, 8'hff);
        write_reg(REG_SCROLL, 8'hff);
        write_reg(REG_SCROLL, 8'h00);
        write_reg(REG_SCROLL, 8'h00);
        // top of the 14-bit space, then both step sizes
        write_reg(REG_ADDR, 8'hff);
        write_reg(REG_ADDR, 8'hff);
        read_reg(REG_DATA);
        write_reg(REG_CTRL, 8'h04);
        write_reg(REG_DATA, 8'hff);
        // unused registers and the spare kind
        write_reg(REG_STATUS, 8'hff);
        write_reg(REG_OAM_ADDR, 8'hff);
        write_reg(REG_OAM_DATA, 8'hff);
        put_item(make_item(KIND_SPARE, REG_DATA, 8'hff));
        write_reg(REG_ADDR, 8'h00);
        write_reg(REG_ADDR, 8'h00);

        random_mix(450);

        send_idle_pct = 83;
        recv_idle_pct = 9;
        random_mix(450);

        // no idling from here; hold the receiver off to fill the unit
        send_idle_pct = 0;
        recv_idle_pct = 0;
        long_hold_rq  = 1'b1;
        random_mix(360);

        // rendering on, dots mixed with register traffic
        write_reg(REG_MASK, 8'h1e);
        write_reg(REG_CTRL, 8'h80);
        read_reg(REG_STATUS);
        write_reg(REG_SCROLL, 8'($urandom_range(255)));
        write_reg(REG_SCROLL, 8'hff);
        for (k = 0; k < 60; k++) begin
            if ($urandom_range(7) != 0) begin
                run_ticks(1);
            end else begin
                case ($urandom_range(3))
                    0: write_reg(REG_SCROLL, 8'($urandom_range(255)));
                    1: read_reg(REG_STATUS);
                    2: data_port_access();
                    default: write_reg(REG_CTRL, 8'($urandom_range(255)));
                endcase
            end
        end
        write_reg(REG_MASK, 8'h00);

        // stride 32 across the top of the 14-bit space
        read_reg(REG_STATUS);
        write_reg(REG_CTRL, 8'h04);
        write_reg(REG_ADDR, 8'h3f);
        write_reg(REG_ADDR, 8'he0);
        for (k = 0; k < 40; k++) begin
            data_port_access();
        end

        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) begin
            @(posedge i_clk);
        end
        repeat (8) @(posedge i_clk);

        $display("covered %0d items: %0d random, %0d nmi pulses, %0d odd-frame skips, %0d wraps",
                 item_count, random_total, nmi_count, skip_count, wrap_count);
        $display("three idling patterns, a long receiver hold-off and vblank-line register traffic");
        if (fail_count == 0) begin
            $display("video_scroll_address_and_dot_timing_unit_tb passed");
        end else begin
            $display("video_scroll_address_and_dot_timing_unit_tb failed");
        end
        $finish;
    end

endmodule
